// ===== sv/segment_reorder_buffer_unit_macros.svh =====
// Assertion macros shared by the segment reorder buffer RTL.
`ifndef SEGMENT_REORDER_BUFFER_UNIT_MACROS_SVH
`define SEGMENT_REORDER_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define SRB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define SRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/srb_pkg.sv =====
// Shared types and constants of the segment reorder buffer.
`timescale 1ns / 1ps
package srb_pkg;

   // Field widths of one request and one result.
   localparam int TAG_W = 16;
   localparam int LEN_W = 11;
   localparam int HDL_W = 16;
   localparam int STS_W = 2;

   // Packed stream layout: tag, then length, then handle, padded to bytes.
   localparam int LEN_LSB = TAG_W;
   localparam int HDL_LSB = TAG_W + LEN_W;
   localparam int DATA_W  = ((TAG_W + LEN_W + HDL_W + 7) / 8) * 8;

   // Slot table; the depth is a power of two that divides the tag space.
   localparam int DEPTH  = 16;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam logic [TAG_W-1:0] DEPTH_TAG = TAG_W'(DEPTH);

   // Most segments released for one request.
   localparam int MAX_OUT = 16;
   localparam int CNT_W   = $clog2(MAX_OUT + 1);
   localparam logic [CNT_W-1:0] CNT_FINAL = CNT_W'(MAX_OUT - 1);

   // Result queue between the intake and the output stage.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam logic [QCNT_W-1:0] QDEPTH_CNT = QCNT_W'(QDEPTH);

   typedef enum logic [STS_W-1:0] {
      STS_RELEASED      = 2'd0,
      STS_OUT_OF_WINDOW = 2'd1,
      STS_SLOT_BUSY     = 2'd2
   } status_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_DRAIN
   } front_state_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] length;
      logic [HDL_W-1:0] handle;
      status_type       status;
      logic             last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type entry;
   } queue_push_type;

   typedef struct packed {
      logic       valid;
      result_type entry;
   } queue_head_type;

endpackage

// ===== sv/srb_front.sv =====
// Intake: classifies each request, parks it in the slot table and walks the in-order releases.
`timescale 1ns / 1ps
module srb_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [srb_pkg::TAG_W-1:0]  req_tag,
   input  logic [srb_pkg::LEN_W-1:0]  req_length,
   input  logic [srb_pkg::HDL_W-1:0]  req_handle,
   input  logic                       q_full,
   output srb_pkg::queue_push_type    q_push,
   output logic                       busy
);

   srb_pkg::front_state_type state_ff, state_in;
   logic [srb_pkg::TAG_W-1:0]  expected_ff, expected_in;
   logic [srb_pkg::DEPTH-1:0]  valid_ff, valid_in;
   logic [srb_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [srb_pkg::LEN_W-1:0]  len_ff [srb_pkg::DEPTH];
   logic [srb_pkg::HDL_W-1:0]  hdl_ff [srb_pkg::DEPTH];

   logic [srb_pkg::SLOT_W-1:0] head, head_next, slot;
   logic [srb_pkg::TAG_W-1:0]  offset;
   logic                       in_window, occupied, accept, store_we, final_release;

   // Window check and slot selection relative to the expected tag.
   assign head          = expected_ff[srb_pkg::SLOT_W-1:0];
   assign head_next     = head + srb_pkg::SLOT_W'(1);
   assign offset        = req_tag - expected_ff;
   assign in_window     = offset < srb_pkg::DEPTH_TAG;
   assign slot          = head + offset[srb_pkg::SLOT_W-1:0];
   assign occupied      = valid_ff[slot];
   assign final_release = (cnt_ff == srb_pkg::CNT_FINAL) || !valid_ff[head_next];

   assign req_ready = (state_ff == srb_pkg::FRONT_IDLE) && !q_full;
   assign accept    = req_valid && req_ready;
   assign busy      = (state_ff == srb_pkg::FRONT_DRAIN);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= srb_pkg::FRONT_IDLE;
         expected_ff <= srb_pkg::TAG_W'(1);
         valid_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         valid_ff    <= valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Descriptor store; an entry is read only while its valid bit is set.
   always_ff @(posedge clock) begin
      if (store_we) begin
         len_ff[slot] <= req_length;
         hdl_ff[slot] <= req_handle;
      end
   end

   // Classification of a new request and the release walk.
   always_comb begin
      state_in    = state_ff;
      expected_in = expected_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      store_we    = 1'b0;
      q_push      = '0;
      unique case (state_ff)
         srb_pkg::FRONT_IDLE: begin
            if (accept) begin
               q_push.entry.tag  = req_tag;
               q_push.entry.last = 1'b1;
               if (!in_window) begin
                  q_push.valid        = 1'b1;
                  q_push.entry.status = srb_pkg::STS_OUT_OF_WINDOW;
               end else if (occupied) begin
                  q_push.valid        = 1'b1;
                  q_push.entry.status = srb_pkg::STS_SLOT_BUSY;
               end else begin
                  // Park; release starts only if the head slot becomes ready.
                  store_we       = 1'b1;
                  valid_in[slot] = 1'b1;
                  cnt_in         = '0;
                  if ((offset == '0) || valid_ff[head]) begin
                     state_in = srb_pkg::FRONT_DRAIN;
                  end
               end
            end
         end
         srb_pkg::FRONT_DRAIN: begin
            if (!valid_ff[head]) begin
               state_in = srb_pkg::FRONT_IDLE;
            end else if (!q_full) begin
               q_push.valid        = 1'b1;
               q_push.entry.tag    = expected_ff;
               q_push.entry.length = len_ff[head];
               q_push.entry.handle = hdl_ff[head];
               q_push.entry.status = srb_pkg::STS_RELEASED;
               q_push.entry.last   = final_release;
               valid_in[head]      = 1'b0;
               expected_in         = expected_ff + srb_pkg::TAG_W'(1);
               cnt_in              = cnt_ff + srb_pkg::CNT_W'(1);
               if (final_release) begin
                  state_in = srb_pkg::FRONT_IDLE;
               end
            end
         end
         default: begin
            state_in = srb_pkg::FRONT_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/srb_queue.sv =====
// Small result queue that decouples the intake from the output stage.
`timescale 1ns / 1ps
module srb_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  srb_pkg::queue_push_type push,
   output logic                    full,
   output srb_pkg::queue_head_type head,
   input  logic                    pop
);

   srb_pkg::result_type         mem_ff [srb_pkg::QDEPTH];
   logic [srb_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [srb_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        do_push, do_pop;

   assign full       = (count_ff == srb_pkg::QDEPTH_CNT);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + srb_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + srb_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + srb_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - srb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== sv/srb_back.sv =====
// Output stage: moves queued results into the response register.
`timescale 1ns / 1ps
module srb_back (
   input  logic                    clock,
   input  logic                    reset,
   input  srb_pkg::queue_head_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output srb_pkg::result_type     rsp_entry
);

   logic                rsp_valid_ff, rsp_valid_in;
   srb_pkg::result_type rsp_entry_ff;
   logic                load;

   // The register takes a new result when empty or when the current one leaves.
   assign load         = !rsp_valid_ff || rsp_ready;
   assign q_pop        = load && q_head.valid;
   assign rsp_valid_in = load ? q_head.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_entry_ff <= q_head.entry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry = rsp_entry_ff;

endmodule

// ===== sv/segment_reorder_buffer_unit.sv =====
// Top level of the segment reorder buffer: intake, result queue and output stage.
//
// Completed segments arrive tagged with a 16-bit sequence number in any order and leave in
// strict tag order, starting at tag one after reset. A tag within sixteen of the next expected
// tag is parked in its slot; every run of consecutive parked segments from the expected tag is
// then released with status zero, the final one of a request marked by tlast. A tag outside
// that window (status one) or one whose slot is taken (status two) gets a single error
// response with zero length and handle and changes nothing. When a request frees parked
// segments, the intake stays busy while they are released, since the release sequencer reads
// one slot of the table each cycle while the result queue is not full. A four-entry result
// queue and an output register let the intake keep working while responses wait.
`timescale 1ns / 1ps
`include "segment_reorder_buffer_unit_macros.svh"
module segment_reorder_buffer_unit (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: seq_tag[15:0], seg_length[26:16], buf_handle[42:27], zero pad.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [srb_pkg::DATA_W-1:0]  req_tdata,
   // rsp_tdata: out_tag[15:0], out_length[26:16], out_handle[42:27], zero pad.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [srb_pkg::DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: status[1:0].
   output logic [srb_pkg::STS_W-1:0]   rsp_tuser,
   output logic                        rsp_tlast
);

   srb_pkg::queue_push_type q_push;
   srb_pkg::queue_head_type q_head;
   srb_pkg::result_type     rsp_entry;
   logic                    q_full, q_pop, front_busy;

   // Request intake and slot table.
   srb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_tag    (req_tdata[0 +: srb_pkg::TAG_W]),
      .req_length (req_tdata[srb_pkg::LEN_LSB +: srb_pkg::LEN_W]),
      .req_handle (req_tdata[srb_pkg::HDL_LSB +: srb_pkg::HDL_W]),
      .q_full     (q_full),
      .q_push     (q_push),
      .busy       (front_busy)
   );

   // Result queue.
   srb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .head  (q_head),
      .pop   (q_pop)
   );

   // Response register.
   srb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_entry (rsp_entry)
   );

   // Response packing.
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0 +: srb_pkg::TAG_W]                = rsp_entry.tag;
      rsp_tdata[srb_pkg::LEN_LSB +: srb_pkg::LEN_W] = rsp_entry.length;
      rsp_tdata[srb_pkg::HDL_LSB +: srb_pkg::HDL_W] = rsp_entry.handle;
   end
   assign rsp_tuser = rsp_entry.status;
   assign rsp_tlast = rsp_entry.last;

   // An error response always closes its request.
   `SRB_ASSERT_SAME(a_error_is_last, rsp_tvalid && (rsp_tuser != srb_pkg::STS_RELEASED), rsp_tlast, "error response without last")
   // The intake never offers a result the queue cannot hold.
   `SRB_ASSERT_SAME(a_push_not_full, q_push.valid, !q_full, "result pushed into a full queue")
   // No request is taken while releases are being walked.
   `SRB_ASSERT_SAME(a_no_intake_in_drain, front_busy, !req_tready, "request taken during release")
   // The final result of a request returns the intake to idle.
   `SRB_ASSERT_NEXT(a_last_ends_drain, !reset && q_push.valid && q_push.entry.last, !front_busy, "intake still busy after last result")

endmodule
